@@ sv/cfpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cfpa_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int ACC_W  = PROD_W + 2;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int WIDE_W = NUM_W + 2;
  localparam int REM_W  = PROD_W + 1;
  localparam int SQR_W  = DATA_WIDTH + 3;
  localparam int IT_W   = $clog2(NUM_W + 1);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MAG = 3'd4;
  localparam logic [2:0] OP_R2C = 3'd5;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic signed [WIDE_W-1:0] SAT_MAX =
    {{(WIDE_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] SAT_MIN =
    {{(WIDE_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    K_ADD, K_SUB, K_MUL, K_DIV, K_DZ, K_MAG, K_R2C, K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                          kind;
    logic signed [DATA_WIDTH-1:0]   a_re;
    logic signed [DATA_WIDTH-1:0]   a_im;
    logic signed [DATA_WIDTH-1:0]   b_re;
    logic signed [DATA_WIDTH-1:0]   b_im;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] val;
    logic                  hit;
  } sat_t;

  function automatic logic signed [WIDE_W-1:0] sext_d(input logic signed [DATA_WIDTH-1:0] x);
    sext_d = {{(WIDE_W-DATA_WIDTH){x[DATA_WIDTH-1]}}, x};
  endfunction

  function automatic sat_t saturate(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.val = SAT_MAX[DATA_WIDTH-1:0];
      r.hit = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val = SAT_MIN[DATA_WIDTH-1:0];
      r.hit = 1'b1;
    end else begin
      r.val = v[DATA_WIDTH-1:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/complex_fixed_point_alu_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake           payload
// request   in         start, busy         op, a_re, a_im, b_re, b_im
// result    out        done (one cycle)    res_re, res_im, status
//
// A two-entry queue takes requests while the back end works on an earlier one.
// Add, subtract, real-to-complex, divide by zero, undefined op: finished from the back end's idle state.
// Multiply: four products through the one shared 32x32 multiplier.
// Magnitude: two products, then a radix-2 square root, one bit a cycle.
// Divide: six products, then two 80-step restoring divisions.
// Synchronous reset empties the queue; the receiver cannot stall, busy marks a full queue.
module complex_fixed_point_alu_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic [2:0]                             op,
  input  wire logic signed [cfpa_pkg::DATA_WIDTH-1:0] a_re,
  input  wire logic signed [cfpa_pkg::DATA_WIDTH-1:0] a_im,
  input  wire logic signed [cfpa_pkg::DATA_WIDTH-1:0] b_re,
  input  wire logic signed [cfpa_pkg::DATA_WIDTH-1:0] b_im,
  output logic                                        busy,
  output logic                                        done,
  output logic signed [cfpa_pkg::DATA_WIDTH-1:0]      res_re,
  output logic signed [cfpa_pkg::DATA_WIDTH-1:0]      res_im,
  output logic [1:0]                                  status
);
  import cfpa_pkg::*;

  head_t head;
  logic  pop;

  cfpa_front u_front (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (op),
    .a_re (a_re),
    .a_im (a_im),
    .b_re (b_re),
    .b_im (b_im),
    .pop  (pop),
    .busy (busy),
    .head (head)
  );

  cfpa_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .pop   (pop),
    .done  (done),
    .res_re(res_re),
    .res_im(res_im),
    .status(status)
  );

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3) else $error("bad status code");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_DZ |-> res_re == '0 && res_im == '0)
    else $error("divide by zero result not zero");
  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !busy && !done) else $error("busy or done after reset");
`endif

endmodule
`default_nettype wire

@@ sv/cfpa_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cfpa_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [2:0]                           op,
  input  wire logic signed [cfpa_pkg::DATA_WIDTH-1:0] a_re,
  input  wire logic signed [cfpa_pkg::DATA_WIDTH-1:0] a_im,
  input  wire logic signed [cfpa_pkg::DATA_WIDTH-1:0] b_re,
  input  wire logic signed [cfpa_pkg::DATA_WIDTH-1:0] b_im,
  input  wire logic                                 pop,
  output logic                                      busy,
  output cfpa_pkg::head_t                           head
);
  import cfpa_pkg::*;

  item_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  item_t              cls;
  logic               push;
  logic               take;

  always_comb begin
    cls.a_re = a_re;
    cls.a_im = a_im;
    cls.b_re = b_re;
    cls.b_im = b_im;
    unique case (op)
      OP_ADD:  cls.kind = K_ADD;
      OP_SUB:  cls.kind = K_SUB;
      OP_MUL:  cls.kind = K_MUL;
      OP_DIV:  cls.kind = (b_re == '0 && b_im == '0) ? K_DZ : K_DIV;
      OP_MAG:  cls.kind = K_MAG;
      OP_R2C:  cls.kind = K_R2C;
      default: cls.kind = K_NOP;
    endcase
  end

  assign busy       = (count == Q_CNT_W'(Q_DEPTH));
  assign push       = start && !busy;
  assign take       = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(take);
    end
  end

endmodule
`default_nettype wire

@@ sv/cfpa_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cfpa_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cfpa_pkg::head_t               head,
  output logic                               pop,
  output logic                               done,
  output logic [cfpa_pkg::DATA_WIDTH-1:0]    res_re,
  output logic [cfpa_pkg::DATA_WIDTH-1:0]    res_im,
  output logic [1:0]                         status
);
  import cfpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PROD = 5'b00010,
    S_FIN  = 5'b00100,
    S_DIV  = 5'b01000,
    S_SQRT = 5'b10000
  } state_t;

  localparam logic [1:0] SEL_AR = 2'd0;
  localparam logic [1:0] SEL_AI = 2'd1;
  localparam logic [1:0] SEL_BR = 2'd2;
  localparam logic [1:0] SEL_BI = 2'd3;
  localparam logic [1:0] DST_0  = 2'd0;
  localparam logic [1:0] DST_1  = 2'd1;
  localparam logic [1:0] DST_2  = 2'd2;

  state_t state;
  kind_t  kind;
  logic signed [DATA_WIDTH-1:0] ar, ai, br, bi;
  logic signed [ACC_W-1:0]  acc0, acc1, acc2;
  logic signed [PROD_W-1:0] prod;
  logic [1:0]               prod_dst;
  logic                     prod_sub;
  logic                     prod_v;
  logic [2:0]               cnt;
  logic [2:0]               nsteps;
  logic [1:0]               xs, ys, dst;
  logic                     sub;
  logic signed [DATA_WIDTH-1:0] xv, yv;
  logic signed [ACC_W-1:0]  pext;
  logic [IT_W-1:0]          iter;
  logic                     ld;
  logic                     part;
  logic                     neg;
  logic                     sat_acc;
  logic [NUM_W-1:0]         num;
  logic [NUM_W-1:0]         quo;
  logic [REM_W-1:0]         rem;
  logic [REM_W-1:0]         rem_sh;
  logic [REM_W-1:0]         den_ext;
  logic signed [ACC_W-1:0]  dsrc;
  logic signed [ACC_W-1:0]  dmag;
  logic signed [WIDE_W-1:0] qv;
  logic [PROD_W-1:0]        sq_n;
  logic [SQR_W-1:0]         sq_rem;
  logic [SQR_W-1:0]         sq_sh;
  logic [SQR_W-1:0]         sq_trial;
  logic [DATA_WIDTH-1:0]    root;
  logic signed [WIDE_W-1:0] s_re, s_im;
  sat_t                     sr, si;
  sat_t                     mr, mi;
  sat_t                     dq;

  function automatic logic signed [DATA_WIDTH-1:0] pick(
    input logic [1:0] s, input logic signed [DATA_WIDTH-1:0] p0,
    input logic signed [DATA_WIDTH-1:0] p1, input logic signed [DATA_WIDTH-1:0] p2,
    input logic signed [DATA_WIDTH-1:0] p3);
    unique case (s)
      SEL_AR:  pick = p0;
      SEL_AI:  pick = p1;
      SEL_BR:  pick = p2;
      default: pick = p3;
    endcase
  endfunction

  always_comb begin
    xs = SEL_AR;
    ys = SEL_BR;
    dst = DST_0;
    sub = 1'b0;
    nsteps = 3'd0;
    unique case (kind)
      K_MUL: begin
        nsteps = 3'd4;
        unique case (cnt)
          3'd0:    begin xs = SEL_AR; ys = SEL_BR; dst = DST_0; end
          3'd1:    begin xs = SEL_AI; ys = SEL_BI; dst = DST_0; sub = 1'b1; end
          3'd2:    begin xs = SEL_AR; ys = SEL_BI; dst = DST_1; end
          default: begin xs = SEL_AI; ys = SEL_BR; dst = DST_1; end
        endcase
      end
      K_DIV: begin
        nsteps = 3'd6;
        unique case (cnt)
          3'd0:    begin xs = SEL_AR; ys = SEL_BR; dst = DST_0; end
          3'd1:    begin xs = SEL_AI; ys = SEL_BI; dst = DST_0; end
          3'd2:    begin xs = SEL_AI; ys = SEL_BR; dst = DST_1; end
          3'd3:    begin xs = SEL_AR; ys = SEL_BI; dst = DST_1; sub = 1'b1; end
          3'd4:    begin xs = SEL_BR; ys = SEL_BR; dst = DST_2; end
          default: begin xs = SEL_BI; ys = SEL_BI; dst = DST_2; end
        endcase
      end
      K_MAG: begin
        nsteps = 3'd2;
        unique case (cnt)
          3'd0:    begin xs = SEL_AR; ys = SEL_AR; dst = DST_2; end
          default: begin xs = SEL_AI; ys = SEL_AI; dst = DST_2; end
        endcase
      end
      default: nsteps = 3'd0;
    endcase
  end

  assign xv   = pick(xs, ar, ai, br, bi);
  assign yv   = pick(ys, ar, ai, br, bi);
  assign pext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    unique case (head.item.kind)
      K_SUB: begin
        s_re = sext_d(head.item.a_re) - sext_d(head.item.b_re);
        s_im = sext_d(head.item.a_im) - sext_d(head.item.b_im);
      end
      K_R2C: begin
        s_re = sext_d(head.item.a_re);
        s_im = '0;
      end
      K_ADD: begin
        s_re = sext_d(head.item.a_re) + sext_d(head.item.b_re);
        s_im = sext_d(head.item.a_im) + sext_d(head.item.b_im);
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
  end

  assign sr = saturate(s_re);
  assign si = saturate(s_im);
  assign mr = saturate({{(WIDE_W-ACC_W){acc0[ACC_W-1]}}, acc0 >>> FRAC_BITS});
  assign mi = saturate({{(WIDE_W-ACC_W){acc1[ACC_W-1]}}, acc1 >>> FRAC_BITS});

  assign dsrc    = part ? acc1 : acc0;
  assign dmag    = dsrc[ACC_W-1] ? -dsrc : dsrc;
  assign den_ext = REM_W'(acc2[PROD_W-1:0]);
  assign rem_sh  = {rem[REM_W-2:0], num[NUM_W-1]};
  assign qv      = neg ? -$signed(WIDE_W'(quo)) : $signed(WIDE_W'(quo));
  assign dq      = saturate(qv);

  assign sq_sh    = {sq_rem[SQR_W-3:0], sq_n[PROD_W-1 -: 2]};
  assign sq_trial = SQR_W'({root, 2'b01});

  assign pop = (state == S_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      done <= 1'b0;
      if (prod_v) begin
        unique case (prod_dst)
          DST_0:   acc0 <= prod_sub ? acc0 - pext : acc0 + pext;
          DST_1:   acc1 <= prod_sub ? acc1 - pext : acc1 + pext;
          default: acc2 <= acc2 + pext;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            kind   <= head.item.kind;
            ar     <= head.item.a_re;
            ai     <= head.item.a_im;
            br     <= head.item.b_re;
            bi     <= head.item.b_im;
            acc0   <= '0;
            acc1   <= '0;
            acc2   <= '0;
            cnt    <= '0;
            prod_v <= 1'b0;
            ld     <= 1'b1;
            part   <= 1'b0;
            if (head.item.kind == K_MUL || head.item.kind == K_DIV ||
                head.item.kind == K_MAG) begin
              state <= S_PROD;
            end else begin
              done   <= 1'b1;
              res_re <= sr.val;
              res_im <= si.val;
              if (head.item.kind == K_DZ) begin
                status <= ST_DZ;
              end else begin
                status <= (sr.hit || si.hit) ? ST_SAT : ST_OK;
              end
            end
          end
        end
        S_PROD: begin
          if (cnt != nsteps) begin
            prod     <= xv * yv;
            prod_dst <= dst;
            prod_sub <= sub;
            prod_v   <= 1'b1;
            cnt      <= cnt + 3'd1;
          end else begin
            prod_v <= 1'b0;
            if (!prod_v) begin
              priority if (kind == K_MUL) begin
                state <= S_FIN;
              end else if (kind == K_DIV) begin
                state <= S_DIV;
              end else begin
                state <= S_SQRT;
              end
            end
          end
        end
        S_FIN: begin
          done   <= 1'b1;
          res_re <= mr.val;
          res_im <= mi.val;
          status <= (mr.hit || mi.hit) ? ST_SAT : ST_OK;
          state  <= S_IDLE;
        end
        S_DIV: begin
          if (ld) begin
            neg  <= dsrc[ACC_W-1];
            num  <= NUM_W'(dmag[PROD_W-1:0]) << FRAC_BITS;
            rem  <= '0;
            quo  <= '0;
            iter <= IT_W'(NUM_W);
            ld   <= 1'b0;
          end else if (iter != '0) begin
            num  <= num << 1;
            iter <= iter - 1'b1;
            if (rem_sh >= den_ext) begin
              rem <= rem_sh - den_ext;
              quo <= {quo[NUM_W-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[NUM_W-2:0], 1'b0};
            end
          end else if (!part) begin
            res_re  <= dq.val;
            sat_acc <= dq.hit;
            part    <= 1'b1;
            ld      <= 1'b1;
          end else begin
            res_im <= dq.val;
            status <= (sat_acc || dq.hit) ? ST_SAT : ST_OK;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_SQRT: begin
          if (ld) begin
            sq_n   <= acc2[PROD_W-1:0];
            sq_rem <= '0;
            root   <= '0;
            iter   <= IT_W'(DATA_WIDTH);
            ld     <= 1'b0;
          end else if (iter != '0) begin
            sq_n <= sq_n << 2;
            iter <= iter - 1'b1;
            if (sq_sh >= sq_trial) begin
              sq_rem <= sq_sh - sq_trial;
              root   <= {root[DATA_WIDTH-2:0], 1'b1};
            end else begin
              sq_rem <= sq_sh;
              root   <= {root[DATA_WIDTH-2:0], 1'b0};
            end
          end else begin
            res_re <= root[DATA_WIDTH-1] ? SAT_MAX[DATA_WIDTH-1:0] : root;
            res_im <= '0;
            status <= root[DATA_WIDTH-1] ? ST_SAT : ST_OK;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import cfpa_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;

  typedef struct {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic [1:0]           st;
  } cplx_res_t;

  class alu_scoreboard;
    cplx_res_t pending[$];
    int errors = 0;

    function automatic logic signed [DW-1:0] clamp(input logic signed [199:0] v,
                                                   inout bit hit);
      logic signed [199:0] hi, lo;
      hi = (200'sd1 <<< (DW - 1)) - 1;
      lo = -(200'sd1 <<< (DW - 1));
      if (v > hi) begin
        hit = 1;
        return hi[DW-1:0];
      end
      if (v < lo) begin
        hit = 1;
        return lo[DW-1:0];
      end
      return v[DW-1:0];
    endfunction

    function automatic logic signed [199:0] quot_trunc(input logic signed [199:0] n,
                                                       input logic signed [199:0] d);
      logic [199:0] m, q;
      m = (n < 0) ? -n : n;
      q = (m << FB) / d;
      return (n < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [99:0] root(input logic [199:0] n);
      logic [99:0] r, c;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
        c = r | (100'd1 << i);
        if ({100'd0, c} * {100'd0, c} <= n) r = c;
      end
      return r;
    endfunction

    function void note_request(logic [2:0] opc, logic signed [DW-1:0] ar,
                               logic signed [DW-1:0] ai, logic signed [DW-1:0] br,
                               logic signed [DW-1:0] bi);
      logic signed [199:0] xr, xi, yr, yi, re, im, den;
      cplx_res_t e;
      bit hit;
      xr = ar; xi = ai; yr = br; yi = bi;
      re = 0; im = 0; hit = 0; e.st = ST_OK;
      case (opc)
        OP_ADD: begin re = xr + yr; im = xi + yi; end
        OP_SUB: begin re = xr - yr; im = xi - yi; end
        OP_MUL: begin
          re = (xr * yr - xi * yi) >>> FB;
          im = (xr * yi + xi * yr) >>> FB;
        end
        OP_DIV: begin
          den = yr * yr + yi * yi;
          if (den == 0) e.st = ST_DZ;
          else begin
            re = quot_trunc(xr * yr + xi * yi, den);
            im = quot_trunc(xi * yr - xr * yi, den);
          end
        end
        OP_MAG: re = $signed({100'd0, root(xr * xr + xi * xi)});
        OP_R2C: re = xr;
        default: ;
      endcase
      e.re = clamp(re, hit);
      e.im = clamp(im, hit);
      if (e.st == ST_OK && hit) e.st = ST_SAT;
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [DW-1:0] re, logic signed [DW-1:0] im,
                               logic [1:0] st);
      cplx_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h %h %0d", $time, re, im, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (re !== e.re) begin
        $display("%0t: res_re expected %h actual %h", $time, e.re, re);
        errors++;
      end
      if (im !== e.im) begin
        $display("%0t: res_im expected %h actual %h", $time, e.im, im);
        errors++;
      end
      if (st !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start;
  logic [2:0] op;
  logic signed [DW-1:0] a_re, a_im, b_re, b_im;
  logic busy, done;
  logic signed [DW-1:0] res_re, res_im;
  logic [1:0] status;

  alu_scoreboard sb = new();
  int burst_left = 0;

  complex_fixed_point_alu_unit dut (
    .clk(clk), .rst(rst), .start(start), .op(op), .a_re(a_re), .a_im(a_im),
    .b_re(b_re), .b_im(b_im), .busy(busy), .done(done), .res_re(res_re),
    .res_im(res_im), .status(status)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(res_re, res_im, status);
  end

  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(DW-1){1'b1}}};
      1: return {1'b1, {(DW-1){1'b0}}};
      2: return 0;
      3: return $signed($urandom_range(0, 8)) <<< FB;
      4: return -($signed($urandom_range(0, 8)) <<< FB);
      5: return $signed(DW'($urandom_range(0, 2**20))) - 2**19;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(logic [2:0] o, logic signed [DW-1:0] ar,
                              logic signed [DW-1:0] ai, logic signed [DW-1:0] br,
                              logic signed [DW-1:0] bi);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1; op <= o; a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
    do @(posedge clk); while (busy);
    sb.note_request(o, ar, ai, br, bi);
    @(negedge clk);
  endtask

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE = 1 <<< FB;

  initial begin
    int wait_cycles;
    logic [2:0] o;
    rst = 1; start = 0; op = 0; a_re = 0; a_im = 0; b_re = 0; b_im = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send_request(OP_ADD, MAXV, MINV, MAXV, MINV);
    send_request(OP_ADD, ONE, -ONE, ONE, ONE);
    send_request(OP_SUB, MINV, MAXV, MAXV, MINV);
    send_request(OP_SUB, ONE, 3 * ONE, -ONE, ONE);
    send_request(OP_MUL, MAXV, MAXV, MAXV, MINV);
    send_request(OP_MUL, MINV, MINV, MINV, MINV);
    send_request(OP_MUL, -1, 1, 1, 1);
    send_request(OP_DIV, ONE, ONE, 0, 0);
    send_request(OP_DIV, MAXV, MAXV, 1, 0);
    send_request(OP_DIV, -ONE, 2 * ONE, ONE, -ONE);
    send_request(OP_DIV, MINV, MINV, MINV, MINV);
    send_request(OP_MAG, MINV, MINV, 5, 5);
    send_request(OP_MAG, 3 * ONE, -4 * ONE, 0, 0);
    send_request(OP_R2C, MINV, MAXV, 7, 7);
    send_request(3'd6, ONE, ONE, ONE, ONE);
    send_request(3'd7, MAXV, MAXV, MAXV, MAXV);
    for (int n = 0; n < 1500; n++) begin
      o = $urandom_range(0, 7);
      if (o > 5 && $urandom_range(0, 3) != 0) o = $urandom_range(0, 5);
      send_request(o, pick_value(), pick_value(), pick_value(), pick_value());
    end
    start <= 0;
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("complex_fixed_point_alu_unit test passed");
    else
      $display("complex_fixed_point_alu_unit test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("complex_fixed_point_alu_unit test failed");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/cfpa_pkg.sv
sv/cfpa_front.sv
sv/cfpa_back.sv
sv/complex_fixed_point_alu_unit.sv
verif/tb.sv
